### design/pareto_archive_filter_unit_macros.svh
// Assertion macros for the Pareto archive filter.
// Included by modules that carry concurrent checks.
`ifndef PARETO_ARCHIVE_FILTER_UNIT_MACROS_SVH
`define PARETO_ARCHIVE_FILTER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PAF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define PAF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/paf_pkg.sv
// Shared constants for the Pareto archive filter.
// No dependencies.
package paf_pkg;
   localparam int KEY_W  = 32;
   localparam int OBJ_W  = 32;
   localparam int IN_OBJ = 4;
   localparam int CFG_W  = 3;
   localparam int STAT_W = 3;
   localparam int HELD_W = 7;
   localparam int REQ_DATA_W = KEY_W + IN_OBJ * OBJ_W;
   localparam int RSP_DATA_W = 8;

   localparam logic [CFG_W-1:0] OBJ_RESET = 3'd2;

   localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STAT_W-1:0] ST_DOMINATED = 3'd1;
   localparam logic [STAT_W-1:0] ST_DUP_KEY   = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STAT_W-1:0] ST_PRUNED    = 3'd4;

   localparam logic CMD_OFFER = 1'b0;
   localparam logic CMD_PRUNE = 1'b1;
endpackage

### design/pareto_archive_filter_unit.sv
// Pareto archive filter: an offer scans all CAPACITY entries.
// Prune loads each valid entry and scans the archive against it.
// One operation at a time; the single-port entry memory allows one
// read per cycle. Synchronous reset empties the archive at once
// through per-entry valid flops.
// Depends on paf_pkg and pareto_archive_filter_unit_macros.svh.
`include "pareto_archive_filter_unit_macros.svh"
module pareto_archive_filter_unit
   import paf_pkg::*;
#(
   parameter int CAPACITY       = 64,
   parameter int MAX_OBJECTIVES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // point_key, objective_a, objective_b, objective_c, objective_d
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // entries_held, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [STAT_W-1:0]     rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic [CFG_W-1:0]      csr_wr_data
);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int NO_W  = $clog2(MAX_OBJECTIVES + 1);
   localparam int ROW_W = KEY_W + MAX_OBJECTIVES * OBJ_W;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_OSCAN = 3'd1;
   localparam logic [2:0] S_ODEC  = 3'd2;
   localparam logic [2:0] S_PLOAD = 3'd3;
   localparam logic [2:0] S_PWAIT = 3'd4;
   localparam logic [2:0] S_PSCAN = 3'd5;
   localparam logic [2:0] S_PCLR  = 3'd6;
   localparam logic [2:0] S_FIN   = 3'd7;

   logic [ROW_W-1:0] mem [CAPACITY];
   logic [ROW_W-1:0] rd_data_ff;

   logic [2:0]          state_ff, state_in;
   logic [CFG_W-1:0]    cfg_ff;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [CAPACITY-1:0] mark_ff, mark_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic                issue_ff, issue_in;
   logic                pv_ff;
   logic [IDX_W-1:0]    pidx_ff;
   logic [IDX_W-1:0]    b_ff, b_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                dom_ff, dom_in;
   logic                dup_ff, dup_in;
   logic                free_ff, free_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic [STAT_W-1:0]   stat_ff, stat_in;
   logic                rsp_valid_ff;
   logic [STAT_W-1:0]   rsp_stat_ff;
   logic [HELD_W-1:0]   rsp_held_ff;

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [NO_W-1:0]  n_eff;

   // stored row p dominates row q on the first n objectives
   function automatic logic dominates(input logic [ROW_W-1:0] p,
                                      input logic [ROW_W-1:0] q,
                                      input logic [NO_W-1:0] n);
      logic worse;
      logic better;
      worse  = 1'b0;
      better = 1'b0;
      for (int j = 0; j < MAX_OBJECTIVES; j++) begin
         if (NO_W'(j) < n) begin
            if ($signed(p[j*OBJ_W +: OBJ_W]) > $signed(q[j*OBJ_W +: OBJ_W])) worse = 1'b1;
            if ($signed(p[j*OBJ_W +: OBJ_W]) < $signed(q[j*OBJ_W +: OBJ_W])) better = 1'b1;
         end
      end
      return better & ~worse;
   endfunction

   always_comb begin
      if (cfg_ff == '0) n_eff = NO_W'(1);
      else if (32'(cfg_ff) > MAX_OBJECTIVES) n_eff = NO_W'(MAX_OBJECTIVES);
      else n_eff = NO_W'(cfg_ff);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_held_ff);

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      mark_in  = mark_ff;
      count_in = count_ff;
      cnt_in   = cnt_ff;
      issue_in = 1'b0;
      b_in     = b_ff;
      row_in   = row_ff;
      dom_in   = dom_ff;
      dup_in   = dup_ff;
      free_in  = free_ff;
      slot_in  = slot_ff;
      stat_in  = stat_ff;
      rd_en    = 1'b0;
      rd_addr  = cnt_ff;
      wr_en    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cnt_in = '0;
               if (req_tuser == CMD_PRUNE) begin
                  mark_in  = '0;
                  b_in     = '0;
                  state_in = S_PLOAD;
               end else begin
                  row_in = '0;
                  row_in[ROW_W-1 -: KEY_W] = req_tdata[KEY_W-1:0];
                  for (int j = 0; j < MAX_OBJECTIVES; j++) begin
                     if (j < IN_OBJ)
                        row_in[j*OBJ_W +: OBJ_W] = req_tdata[KEY_W + j*OBJ_W +: OBJ_W];
                  end
                  dom_in   = 1'b0;
                  dup_in   = 1'b0;
                  free_in  = 1'b0;
                  issue_in = 1'b1;
                  state_in = S_OSCAN;
               end
            end
         end
         S_OSCAN: begin
            if (issue_ff) begin
               rd_en = 1'b1;
               if (cnt_ff != LAST) begin
                  cnt_in   = cnt_ff + 1'b1;
                  issue_in = 1'b1;
               end
            end
            if (pv_ff) begin
               if (valid_ff[pidx_ff]) begin
                  if (dominates(rd_data_ff, row_ff, n_eff)) dom_in = 1'b1;
                  if (rd_data_ff[ROW_W-1 -: KEY_W] == row_ff[ROW_W-1 -: KEY_W]) dup_in = 1'b1;
               end else if (!free_ff) begin
                  free_in = 1'b1;
                  slot_in = pidx_ff;
               end
               if (pidx_ff == LAST) state_in = S_ODEC;
            end
         end
         S_ODEC: begin
            if (dom_ff) stat_in = ST_DOMINATED;
            else if (dup_ff) stat_in = ST_DUP_KEY;
            else if (!free_ff) stat_in = ST_FULL;
            else begin
               stat_in  = ST_INSERTED;
               wr_en    = 1'b1;
               valid_in[slot_ff] = 1'b1;
               count_in = count_ff + 1'b1;
            end
            state_in = S_FIN;
         end
         S_PLOAD: begin
            rd_addr = b_ff;
            if (valid_ff[b_ff]) begin
               rd_en    = 1'b1;
               state_in = S_PWAIT;
            end else if (b_ff == LAST) begin
               state_in = S_PCLR;
            end else begin
               b_in = b_ff + 1'b1;
            end
         end
         S_PWAIT: begin
            row_in   = rd_data_ff;
            cnt_in   = '0;
            issue_in = 1'b1;
            state_in = S_PSCAN;
         end
         S_PSCAN: begin
            if (issue_ff) begin
               rd_en = 1'b1;
               if (cnt_ff != LAST) begin
                  cnt_in   = cnt_ff + 1'b1;
                  issue_in = 1'b1;
               end
            end
            if (pv_ff) begin
               if (valid_ff[pidx_ff] && pidx_ff != b_ff && !mark_ff[b_ff]
                   && dominates(rd_data_ff, row_ff, n_eff)) begin
                  mark_in[b_ff] = 1'b1;
                  count_in      = count_ff - 1'b1;
               end
               if (pidx_ff == LAST) begin
                  if (b_ff == LAST) state_in = S_PCLR;
                  else begin
                     b_in     = b_ff + 1'b1;
                     state_in = S_PLOAD;
                  end
               end
            end
         end
         S_PCLR: begin
            valid_in = valid_ff & ~mark_ff;
            stat_in  = ST_PRUNED;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // entry memory: one port, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) mem[slot_ff] <= row_ff;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      mark_ff <= mark_in;
      cnt_ff  <= cnt_in;
      b_ff    <= b_in;
      row_ff  <= row_in;
      dom_ff  <= dom_in;
      dup_ff  <= dup_in;
      free_ff <= free_in;
      slot_ff <= slot_in;
      stat_ff <= stat_in;
      pidx_ff <= rd_addr;
      if (state_ff == S_FIN && (!rsp_valid_ff || rsp_tready)) begin
         rsp_stat_ff <= stat_ff;
         rsp_held_ff <= HELD_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cfg_ff       <= OBJ_RESET;
         valid_ff     <= '0;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
         pv_ff    <= rd_en & (state_ff != S_PLOAD);
         if (csr_wr_en) cfg_ff <= csr_wr_data;
         if (state_ff == S_FIN && (!rsp_valid_ff || rsp_tready)) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   `PAF_ASSERT_IMP(a_count_cap, clock, reset, 1'b1, 32'(count_ff) <= CAPACITY,
      "entry count above capacity")
   `PAF_ASSERT_IMP(a_full_means_full, clock, reset, state_ff == S_ODEC && !free_ff,
      32'(count_ff) == CAPACITY, "no free slot but archive not full")
   `PAF_ASSERT_IMP(a_pv_in_scan, clock, reset, pv_ff,
      state_ff == S_OSCAN || state_ff == S_PSCAN || state_ff == S_PWAIT,
      "read data outside a scan")
   `PAF_ASSERT_NXT(a_prune_clears, clock, reset, state_ff == S_PCLR,
      (valid_ff & $past(mark_ff)) == '0, "marked entry still valid after prune")
endmodule

### sim/testbench.sv
// Self-checking bench for pareto_archive_filter_unit: offers and prunes points,
// predicts status and occupancy from a local archive copy. Depends on paf_pkg.
module testbench;
   import paf_pkg::*;

   localparam int CAP   = 64;
   localparam int MAXOB = 4;
   localparam int WDOG  = 200000;
   localparam int LONG_HOLD = 3000;

   typedef struct packed {
      logic            cmd;
      logic [KEY_W-1:0] key;
      logic [IN_OBJ-1:0][OBJ_W-1:0] obj;
   } point_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [HELD_W-1:0] held;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0] rsp_tuser;
   logic csr_wr_en = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   pareto_archive_filter_unit u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // archive copy used for prediction
   logic            arc_valid [CAP];
   logic [KEY_W-1:0] arc_key  [CAP];
   logic signed [OBJ_W-1:0] arc_obj [CAP][MAXOB];
   int unsigned arc_count;
   logic [CFG_W-1:0] obj_sel;

   point_type   pending_points[$];
   outcome_type expected_outcomes[$];
   logic [KEY_W-1:0] key_pool[$];
   int errors = 0;
   int idle_cycles = 0;
   bit send_hold = 1'b0;
   bit long_stall = 1'b0;
   bit long_done = 1'b0;
   int long_left = 0;

   function automatic bit beats(input logic signed [OBJ_W-1:0] p[MAXOB],
                                input logic signed [OBJ_W-1:0] q[MAXOB]);
      int n;
      bit better;
      n = (obj_sel < 1) ? 1 : (obj_sel > MAXOB) ? MAXOB : obj_sel;
      better = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (p[i] > q[i]) return 1'b0;
         if (p[i] < q[i]) better = 1'b1;
      end
      return better;
   endfunction

   function automatic outcome_type archive_update(input point_type pt);
      outcome_type r;
      logic signed [OBJ_W-1:0] v[MAXOB];
      bit marks[CAP];
      int slot;
      if (pt.cmd == CMD_PRUNE) begin
         for (int b = 0; b < CAP; b++) begin
            marks[b] = 1'b0;
            if (!arc_valid[b]) continue;
            for (int a = 0; a < CAP; a++)
               if (a != b && arc_valid[a] && beats(arc_obj[a], arc_obj[b])) begin
                  marks[b] = 1'b1;
                  break;
               end
         end
         for (int b = 0; b < CAP; b++)
            if (marks[b]) begin
               arc_valid[b] = 1'b0;
               arc_count--;
            end
         r.status = ST_PRUNED;
      end else begin
         for (int j = 0; j < MAXOB; j++) v[j] = (j < IN_OBJ) ? pt.obj[j] : '0;
         r.status = ST_INSERTED;
         for (int i = 0; i < CAP; i++)
            if (arc_valid[i] && beats(arc_obj[i], v)) r.status = ST_DOMINATED;
         if (r.status == ST_INSERTED)
            for (int i = 0; i < CAP; i++)
               if (arc_valid[i] && arc_key[i] == pt.key) r.status = ST_DUP_KEY;
         if (r.status == ST_INSERTED) begin
            slot = CAP;
            for (int i = CAP - 1; i >= 0; i--) if (!arc_valid[i]) slot = i;
            if (slot == CAP) r.status = ST_FULL;
            else begin
               arc_valid[slot] = 1'b1;
               arc_key[slot] = pt.key;
               arc_obj[slot] = v;
               arc_count++;
            end
         end
      end
      r.held = arc_count[HELD_W-1:0];
      return r;
   endfunction

   function automatic logic [OBJ_W-1:0] rand_obj(input int mode);
      case (mode)
         0: return $urandom;
         1: return OBJ_W'($signed($urandom_range(0, 20)) - 10);
         2: return 32'h8000_0000 + $urandom_range(0, 3);
         default: return 32'h7fff_fffc + $urandom_range(0, 3);
      endcase
   endfunction

   task automatic queue_offer(input logic [KEY_W-1:0] k, input int mode);
      point_type p;
      p.cmd = CMD_OFFER;
      p.key = k;
      for (int j = 0; j < IN_OBJ; j++) p.obj[j] = rand_obj(mode);
      pending_points.insert(pending_points.size(), p);
      key_pool.insert(key_pool.size(), k);
   endtask

   task automatic queue_prune();
      point_type p;
      p.cmd = CMD_PRUNE;
      p.key = $urandom;
      for (int j = 0; j < IN_OBJ; j++) p.obj[j] = $urandom;
      pending_points.insert(pending_points.size(), p);
   endtask

   task automatic drain_and_settle();
      wait (pending_points.size() == 0 && !req_tvalid);
      wait (expected_outcomes.size() == 0);
      repeat (CAP * (CAP + 3) + 20) @(posedge clock);
   endtask

   task automatic write_obj_sel(input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      obj_sel = val;
   endtask

   // sender: bursts and gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_outcomes.insert(expected_outcomes.size(),
                                     archive_update(pending_points.pop_front()));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_points.size() > 0 && !send_hold) begin
               req_tvalid <= 1'b1;
               // tdata: point_key, then objectives a..d
               req_tuser <= pending_points[0].cmd;
               req_tdata <= {pending_points[0].obj, pending_points[0].key};
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 12);
               end else if (burst_left == 1) begin
                  burst_left <= 0;
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern and checker
   logic [7:0] stall_lfsr = 8'h5a;
   int stall_count = 0;
   outcome_type got, want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4]
                        ^ stall_lfsr[3]};
         if (long_stall && !long_done) begin
            long_left <= LONG_HOLD;
            long_done <= 1'b1;
            rsp_tready <= 1'b0;
         end else if (long_left > 0) begin
            long_left <= long_left - 1;
            rsp_tready <= 1'b0;
         end else if (stall_count > 0) begin
            stall_count <= stall_count - 1;
            rsp_tready <= 1'b0;
         end else if (stall_lfsr[2:0] == 3'd0) begin
            stall_count <= $urandom_range(1, 6);
            rsp_tready <= 1'b0;
         end else rsp_tready <= 1'b1;
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.held = rsp_tdata[HELD_W-1:0];
            if (expected_outcomes.size() == 0) begin
               $display("%0t: unexpected transfer status=%0d held=%0d",
                        $time, got.status, got.held);
               errors++;
            end else begin
               want = expected_outcomes.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
                  errors++;
               end
               if (got.held !== want.held) begin
                  $display("%0t: entries_held expected %0d actual %0d",
                           $time, want.held, got.held);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset
          || long_left > 0)
         idle_cycles <= 0;
      else if (req_tvalid || expected_outcomes.size() > 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < CAP; i++) arc_valid[i] = 1'b0;
      arc_count = 0;
      obj_sel = OBJ_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, duplicate key, domination, prune on empty archive
      queue_prune();
      queue_offer(32'h0000_0000, 2);
      queue_offer(32'hffff_ffff, 3);
      queue_offer(32'h0000_0000, 3);
      queue_offer(32'h1234_5678, 0);
      queue_offer(32'hffff_ffff, 2);
      queue_prune();
      queue_prune();
      drain_and_settle();

      // full archive under four objectives, many incomparable-free keys
      write_obj_sel(3'd4);
      for (int i = 0; i < 70; i++) queue_offer($urandom, 0);
      queue_prune();
      drain_and_settle();

      // long receiver hold-off while sender keeps offering
      long_stall = 1'b1;
      for (int i = 0; i < 10; i++) queue_offer($urandom, 1);
      wait (long_done && long_left == 0);
      long_stall = 1'b0;
      drain_and_settle();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: write_obj_sel(3'd1);
            1: write_obj_sel(3'd0);
            2: write_obj_sel(3'd7);
            default: write_obj_sel(3'($urandom_range(2, 4)));
         endcase
         for (int i = 0; i < 200; i++) begin
            if ($urandom_range(0, 19) == 0) queue_prune();
            else if (key_pool.size() > 0 && $urandom_range(0, 9) == 0)
               queue_offer(key_pool[$urandom_range(0, key_pool.size() - 1)],
                           $urandom_range(0, 3));
            else queue_offer($urandom, $urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 3));
         end
         queue_prune();
         if (ph == 3) begin
            // pause the sender mid-phase until every result is back
            wait (pending_points.size() <= 100);
            send_hold = 1'b1;
            wait (expected_outcomes.size() == 0);
            send_hold = 1'b0;
         end
         drain_and_settle();
      end

      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

### files.f
+incdir+design
design/paf_pkg.sv
design/pareto_archive_filter_unit.sv
sim/testbench.sv
